### rtl/jtmm_pkg.sv
// ----------------------------------------------------------------------------
// jtmm_pkg
// Shared types and constants for the jet triplet mass matcher.
// ----------------------------------------------------------------------------
package jtmm_pkg;

  localparam int MAX_JETS_DEF = 16;

  localparam int E_W      = 20;
  localparam int P_W      = 21;
  localparam int M_W      = 20;
  localparam int IDX_W    = 4;
  localparam int DELTA_W  = 22;
  localparam int STATUS_W = 2;

  localparam int ES_W   = E_W + 1;
  localparam int PS_W   = P_W + 1;
  localparam int OP_W   = PS_W;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RAD_W  = ACC_W - 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int DIF_W  = ROOT_W + 3;

  localparam int MUL_STEPS  = 5;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = 5;

  localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

  typedef struct packed {
    logic [E_W-1:0]        energy;
    logic signed [P_W-1:0] px;
    logic signed [P_W-1:0] py;
    logic signed [P_W-1:0] pz;
    logic [M_W-1:0]        mass;
  } jet_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_U, S_RD_V, S_RD_L, S_CAP, S_MUL, S_SQI, S_SQ,
    S_DIFF, S_CMP, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic              wr;
    logic              cap_u;
    logic              add_v;
    logic              cap_l;
    logic              mul;
    logic [STEP_W-1:0] step;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              diff;
    logic              cmp;
    logic              clr;
    logic              fin;
    logic              short_evt;
    logic              dropped;
  } dp_cmd_t;

endpackage

### rtl/jet_triplet_mass_matcher_core.sv
// ----------------------------------------------------------------------------
// jet_triplet_mass_matcher_core
// Finds the jet pair whose invariant mass best matches a third jet's mass.
// ----------------------------------------------------------------------------
// Each beat on the input channel (start high while busy is low) loads one
// jet, and busy stays low while an event is loaded. Jets beyond MAX_JETS
// are discarded and reported with status 2.
// The beat with in_last_jet high ends the event: busy rises and the core
// visits every triplet and each of its three pairings. Each pairing is
// paced by the single memory read port, the shared squaring multiplier
// (five steps) and the bit-serial square root (22 steps). With fewer
// than three jets no triplet is visited: the core goes straight from the
// last beat to S_FIN, which forms the result, and then to S_OUT.
// The result is shown for one cycle with out_valid high and cannot be held
// off. Busy falls in the following cycle and the next event may load.
// Reset (rst_n low, synchronous) returns the core to the load phase with
// an empty event; the jet store itself is not cleared.
// ----------------------------------------------------------------------------
module jet_triplet_mass_matcher_core #(
  parameter int MAX_JETS = jtmm_pkg::MAX_JETS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [jtmm_pkg::E_W-1:0]             in_jet_energy,
  input  logic signed [jtmm_pkg::P_W-1:0]      in_jet_px,
  input  logic signed [jtmm_pkg::P_W-1:0]      in_jet_py,
  input  logic signed [jtmm_pkg::P_W-1:0]      in_jet_pz,
  input  logic [jtmm_pkg::M_W-1:0]             in_jet_mass,
  input  logic                                 in_last_jet,
  output logic                                 out_valid,
  output logic [jtmm_pkg::IDX_W-1:0]           out_pair_first,
  output logic [jtmm_pkg::IDX_W-1:0]           out_pair_second,
  output logic [jtmm_pkg::IDX_W-1:0]           out_lone_jet,
  output logic [jtmm_pkg::DELTA_W-1:0]         out_best_delta,
  output logic [jtmm_pkg::STATUS_W-1:0]        out_status
);
  import jtmm_pkg::*;

  localparam int IW = $clog2(MAX_JETS);

  dp_cmd_t       cmd;
  jet_t          wr_data;
  logic [IW-1:0] wr_addr, rd_addr, cur_p, cur_q, cur_l;

  assign wr_data = '{energy: in_jet_energy, px: in_jet_px, py: in_jet_py,
                     pz: in_jet_pz, mass: in_jet_mass};

  jtmm_ctrl #(.MAX_JETS(MAX_JETS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_jet  (in_last_jet),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .cur_p     (cur_p),
    .cur_q     (cur_q),
    .cur_l     (cur_l)
  );

  jtmm_datapath #(.MAX_JETS(MAX_JETS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .cur_p       (cur_p),
    .cur_q       (cur_q),
    .cur_l       (cur_l),
    .pair_first  (out_pair_first),
    .pair_second (out_pair_second),
    .lone_jet    (out_lone_jet),
    .best_delta  (out_best_delta),
    .status      (out_status)
  );

endmodule

### rtl/jtmm_datapath.sv
// ----------------------------------------------------------------------------
// jtmm_datapath
// Jet store, pair four-vector sum, squared mass, square root and best match.
// ----------------------------------------------------------------------------
module jtmm_datapath #(
  parameter int MAX_JETS = jtmm_pkg::MAX_JETS_DEF,
  parameter int IW       = $clog2(MAX_JETS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  jtmm_pkg::dp_cmd_t                  cmd,
  input  logic [IW-1:0]                      wr_addr,
  input  jtmm_pkg::jet_t                     wr_data,
  input  logic [IW-1:0]                      rd_addr,
  input  logic [IW-1:0]                      cur_p,
  input  logic [IW-1:0]                      cur_q,
  input  logic [IW-1:0]                      cur_l,
  output logic [jtmm_pkg::IDX_W-1:0]         pair_first,
  output logic [jtmm_pkg::IDX_W-1:0]         pair_second,
  output logic [jtmm_pkg::IDX_W-1:0]         lone_jet,
  output logic [jtmm_pkg::DELTA_W-1:0]       best_delta,
  output logic [jtmm_pkg::STATUS_W-1:0]      status
);
  import jtmm_pkg::*;

  jet_t mem [MAX_JETS];
  jet_t rdata_r;

  logic [ES_W-1:0]          e_s_r;
  logic signed [PS_W-1:0]   x_s_r, y_s_r, z_s_r;
  logic [M_W-1:0]           mass_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     neg_r;
  logic [RAD_W-1:0]         rad_r;
  logic [ROOT_W-1:0]        root_r;
  logic [REM_W-1:0]         rem_r;
  logic [DELTA_W-1:0]       delta_r;
  logic [DELTA_W-1:0]       best_r;
  logic [IW-1:0]            bp_r, bq_r, bl_r;
  logic                     found_r;

  logic signed [OP_W-1:0]   op;
  logic [REM_W-1:0]         rem_w, trial;
  logic signed [DIF_W-1:0]  m_s, d_s;
  logic [DIF_W-1:0]         d_abs;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    case (cmd.step)
      STEP_W'(0): op = OP_W'(signed'({1'b0, e_s_r}));
      STEP_W'(1): op = x_s_r;
      STEP_W'(2): op = y_s_r;
      default:    op = z_s_r;
    endcase
    rem_w = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    m_s   = neg_r ? -DIF_W'(signed'({1'b0, root_r})) : DIF_W'(signed'({1'b0, root_r}));
    d_s   = m_s - DIF_W'(signed'({1'b0, mass_r}));
    d_abs = d_s[DIF_W-1] ? DIF_W'(-d_s) : DIF_W'(d_s);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_u) begin
      e_s_r <= ES_W'(rdata_r.energy);
      x_s_r <= PS_W'(rdata_r.px);
      y_s_r <= PS_W'(rdata_r.py);
      z_s_r <= PS_W'(rdata_r.pz);
    end
    if (cmd.add_v) begin
      e_s_r <= e_s_r + ES_W'(rdata_r.energy);
      x_s_r <= x_s_r + PS_W'(rdata_r.px);
      y_s_r <= y_s_r + PS_W'(rdata_r.py);
      z_s_r <= z_s_r + PS_W'(rdata_r.pz);
    end
    if (cmd.cap_l) begin
      mass_r <= rdata_r.mass;
    end
    if (cmd.mul) begin
      if (cmd.step < STEP_W'(4)) begin
        prod_r <= op * op;
      end
      if (cmd.step == STEP_W'(1)) begin
        acc_r <= ACC_W'(prod_r);
      end else if (cmd.step != STEP_W'(0)) begin
        acc_r <= acc_r - ACC_W'(prod_r);
      end
    end
    if (cmd.sqrt_init) begin
      neg_r  <= acc_r[ACC_W-1];
      rad_r  <= acc_r[ACC_W-1] ? RAD_W'(-acc_r) : RAD_W'(acc_r);
      root_r <= '0;
      rem_r  <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r <= rad_r << 2;
      if (rem_w >= trial) begin
        rem_r  <= rem_w - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_w;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.diff) begin
      delta_r <= (d_abs > DIF_W'(DELTA_MAX)) ? DELTA_MAX : DELTA_W'(d_abs);
    end
    if (cmd.cmp && (!found_r || delta_r < best_r)) begin
      best_r <= delta_r;
      bp_r   <= cur_p;
      bq_r   <= cur_q;
      bl_r   <= cur_l;
    end
    if (cmd.fin) begin
      if (cmd.short_evt) begin
        pair_first  <= '0;
        pair_second <= '0;
        lone_jet    <= '0;
        best_delta  <= '0;
        status      <= ST_SHORT;
      end else begin
        pair_first  <= IDX_W'(bp_r);
        pair_second <= IDX_W'(bq_r);
        lone_jet    <= IDX_W'(bl_r);
        best_delta  <= best_r;
        status      <= cmd.dropped ? ST_DROP : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      found_r <= 1'b0;
    end else if (cmd.cmp) begin
      found_r <= 1'b1;
    end
  end

endmodule

### rtl/jtmm_ctrl.sv
// ----------------------------------------------------------------------------
// jtmm_ctrl
// Load counter, triplet and pairing sequencer, and datapath command decode.
// ----------------------------------------------------------------------------
module jtmm_ctrl #(
  parameter int MAX_JETS = jtmm_pkg::MAX_JETS_DEF,
  parameter int IW       = $clog2(MAX_JETS),
  parameter int CW       = $clog2(MAX_JETS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last_jet,
  output logic              busy,
  output logic              out_valid,
  output jtmm_pkg::dp_cmd_t cmd,
  output logic [IW-1:0]     wr_addr,
  output logic [IW-1:0]     rd_addr,
  output logic [IW-1:0]     cur_p,
  output logic [IW-1:0]     cur_q,
  output logic [IW-1:0]     cur_l
);
  import jtmm_pkg::*;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                drop_r, drop_nxt;
  logic [IW-1:0]       j_r, j_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                accept;
  logic                last_pt;

  assign accept  = start && (state_r == S_IDLE);
  assign last_pt = (k_r == 2'd2) && !(CW'(b_r) + CW'(1) < cnt_r)
                   && !(CW'(a_r) + CW'(2) < cnt_r) && !(CW'(j_r) + CW'(3) < cnt_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && last_jet) begin
          state_nxt = (cnt_nxt < CW'(3)) ? S_FIN : S_RD_U;
        end
      end
      S_RD_U: state_nxt = S_RD_V;
      S_RD_V: state_nxt = S_RD_L;
      S_RD_L: state_nxt = S_CAP;
      S_CAP:  state_nxt = S_MUL;
      S_MUL:  state_nxt = (step_r == STEP_W'(MUL_STEPS - 1)) ? S_SQI : S_MUL;
      S_SQI:  state_nxt = S_SQ;
      S_SQ:   state_nxt = (step_r == STEP_W'(SQRT_STEPS - 1)) ? S_DIFF : S_SQ;
      S_DIFF: state_nxt = S_CMP;
      S_CMP:  state_nxt = last_pt ? S_FIN : S_RD_U;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    j_nxt    = j_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    step_nxt = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cnt_r < CW'(MAX_JETS)) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          j_nxt = IW'(0);
          a_nxt = IW'(1);
          b_nxt = IW'(2);
          k_nxt = 2'd0;
        end
      end
      S_MUL, S_SQ: step_nxt = step_r + STEP_W'(1);
      S_CMP: begin
        if (k_r != 2'd2) begin
          k_nxt = k_r + 2'd1;
        end else begin
          k_nxt = 2'd0;
          if (CW'(b_r) + CW'(1) < cnt_r) begin
            b_nxt = b_r + IW'(1);
          end else if (CW'(a_r) + CW'(2) < cnt_r) begin
            a_nxt = a_r + IW'(1);
            b_nxt = a_r + IW'(2);
          end else begin
            j_nxt = j_r + IW'(1);
            a_nxt = j_r + IW'(2);
            b_nxt = j_r + IW'(3);
          end
        end
      end
      S_OUT: begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (k_r)
      2'd0:    begin cur_p = j_r; cur_q = a_r; cur_l = b_r; end
      2'd1:    begin cur_p = j_r; cur_q = b_r; cur_l = a_r; end
      default: begin cur_p = a_r; cur_q = b_r; cur_l = j_r; end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.step      = step_r;
    cmd.short_evt = cnt_r < CW'(3);
    cmd.dropped   = drop_r;
    wr_addr       = IW'(cnt_r);
    rd_addr       = cur_p;
    busy          = (state_r != S_IDLE);
    out_valid     = (state_r == S_OUT);
    case (state_r)
      S_IDLE: begin
        cmd.wr  = accept && (cnt_r < CW'(MAX_JETS));
        cmd.clr = accept;
      end
      S_RD_V: begin
        rd_addr   = cur_q;
        cmd.cap_u = 1'b1;
      end
      S_RD_L: begin
        rd_addr   = cur_l;
        cmd.add_v = 1'b1;
      end
      S_CAP:  cmd.cap_l     = 1'b1;
      S_MUL:  cmd.mul       = 1'b1;
      S_SQI:  cmd.sqrt_init = 1'b1;
      S_SQ:   cmd.sqrt_step = 1'b1;
      S_DIFF: cmd.diff      = 1'b1;
      S_CMP:  cmd.cmp       = 1'b1;
      S_FIN:  cmd.fin       = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

endmodule

### rtl/jtmm_checker.sv
// ----------------------------------------------------------------------------
// jtmm_checker
// Port-level checks of the jet triplet mass matcher, bound to the top level.
// ----------------------------------------------------------------------------
module jtmm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_last_jet,
  input logic       out_valid,
  input logic [3:0] out_pair_first,
  input logic [21:0] out_best_delta,
  input logic [1:0] out_status
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_load_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_jet |=> !busy) else $error("busy after a load beat");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_jet |=> busy) else $error("no busy after last beat");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("undefined status");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 2'd1 |-> out_pair_first == 4'd0 && out_best_delta == 22'd0)
    else $error("short event with nonzero fields");

endmodule

bind jet_triplet_mass_matcher_core jtmm_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_last_jet    (in_last_jet),
  .out_valid      (out_valid),
  .out_pair_first (out_pair_first),
  .out_best_delta (out_best_delta),
  .out_status     (out_status)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jet triplet mass matcher testbench
// Loads events of jets through the command port with random gaps, predicts
// the best pair and lone jet for each event in a scoreboard, and checks every
// result field. Covers short events, ties, extreme momenta and delta
// saturation, followed by random events of mostly small size, some overflowing.
// ----------------------------------------------------------------------------
module testbench;
  import jtmm_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  class match_scoreboard;
    typedef struct {
      logic [IDX_W-1:0]    first;
      logic [IDX_W-1:0]    second;
      logic [IDX_W-1:0]    lone;
      logic [DELTA_W-1:0]  delta;
      logic [STATUS_W-1:0] status;
    } match_t;

    jet_t   event_jets[$];
    bit     overflowed;
    match_t pending_matches[$];
    int     errors;
    int     events_seen;
    int     short_events;
    int     dropped_events;

    function void report(string field, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
      errors++;
    endfunction

    function longint unsigned root64(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned pairing_delta(int u, int v, int lone);
      longint e, x, y, z, m2, m, d;
      e = longint'(event_jets[u].energy) + longint'(event_jets[v].energy);
      x = longint'($signed(event_jets[u].px)) + longint'($signed(event_jets[v].px));
      y = longint'($signed(event_jets[u].py)) + longint'($signed(event_jets[v].py));
      z = longint'($signed(event_jets[u].pz)) + longint'($signed(event_jets[v].pz));
      m2 = e * e - (x * x + y * y + z * z);
      if (m2 < 0) m = -longint'(root64(-m2));
      else m = longint'(root64(m2));
      d = m - longint'(event_jets[lone].mass);
      if (d < 0) d = -d;
      return (d > longint'(DELTA_MAX)) ? longint'(DELTA_MAX) : d;
    endfunction

    function void note_jet(jet_t jet, bit last);
      match_t res;
      int n;
      bit found;
      longint unsigned best, d;
      int cp[3], cq[3], cl[3];
      if (event_jets.size() < MAX_JETS_DEF) event_jets.insert(event_jets.size(), jet);
      else overflowed = 1;
      if (!last) return;
      n = event_jets.size();
      found = 0;
      best = 0;
      res = '{default: '0};
      for (int j = 0; j + 2 < n; j++)
        for (int a = j + 1; a + 1 < n; a++)
          for (int b = a + 1; b < n; b++) begin
            cp = '{j, j, a};
            cq = '{a, b, b};
            cl = '{b, a, j};
            for (int k = 0; k < 3; k++) begin
              d = pairing_delta(cp[k], cq[k], cl[k]);
              if (!found || d < best) begin
                found = 1;
                best = d;
                res.first = IDX_W'(cp[k]);
                res.second = IDX_W'(cq[k]);
                res.lone = IDX_W'(cl[k]);
              end
            end
          end
      if (n < 3) begin
        res = '{default: '0};
        res.status = ST_SHORT;
        short_events++;
      end else begin
        res.delta = DELTA_W'(best);
        res.status = overflowed ? ST_DROP : ST_OK;
        if (overflowed) dropped_events++;
      end
      pending_matches.insert(pending_matches.size(), res);
      events_seen++;
      event_jets.delete();
      overflowed = 0;
    endfunction

    function void check(match_t got);
      match_t want;
      if (pending_matches.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
        return;
      end
      want = pending_matches.pop_front();
      if (got.first !== want.first) report("pair_first", got.first, want.first);
      if (got.second !== want.second) report("pair_second", got.second, want.second);
      if (got.lone !== want.lone) report("lone_jet", got.lone, want.lone);
      if (got.delta !== want.delta) report("best_delta", got.delta, want.delta);
      if (got.status !== want.status) report("status", got.status, want.status);
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 start = 0;
  logic                 busy;
  logic [E_W-1:0]       in_jet_energy = '0;
  logic signed [P_W-1:0] in_jet_px = '0;
  logic signed [P_W-1:0] in_jet_py = '0;
  logic signed [P_W-1:0] in_jet_pz = '0;
  logic [M_W-1:0]       in_jet_mass = '0;
  logic                 in_last_jet = 0;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_pair_first;
  logic [IDX_W-1:0]     out_pair_second;
  logic [IDX_W-1:0]     out_lone_jet;
  logic [DELTA_W-1:0]   out_best_delta;
  logic [STATUS_W-1:0]  out_status;

  match_scoreboard sb = new();
  int idle_cycles = 0;
  int jets_sent = 0;

  always #1 clk = ~clk;

  jet_triplet_mass_matcher_core dut (.*);

  always @(posedge clk) begin
    match_scoreboard::match_t got;
    if (rst_n && out_valid) begin
      got.first = out_pair_first;
      got.second = out_pair_second;
      got.lone = out_lone_jet;
      got.delta = out_best_delta;
      got.status = out_status;
      sb.check(got);
    end
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL jet_triplet_mass_matcher_core");
      $finish;
    end
  end

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic random_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) pause_sender(0);
    else if (r < 92) pause_sender($urandom_range(1, 4));
    else pause_sender($urandom_range(10, 60));
  endtask

  task automatic send_jet(jet_t jet, bit last);
    start <= 1;
    in_jet_energy <= jet.energy;
    in_jet_px <= jet.px;
    in_jet_py <= jet.py;
    in_jet_pz <= jet.pz;
    in_jet_mass <= jet.mass;
    in_last_jet <= last;
    do @(posedge clk); while (busy);
    sb.note_jet(jet, last);
    jets_sent++;
    random_pause();
  endtask

  task automatic wait_drained();
    start <= 0;
    while (sb.pending_matches.size() != 0) @(posedge clk);
  endtask

  function automatic jet_t random_jet();
    jet_t jet;
    if ($urandom_range(0, 3) == 0) begin
      jet.energy = E_W'($urandom);
      jet.px = P_W'($urandom);
      jet.py = P_W'($urandom);
      jet.pz = P_W'($urandom);
      jet.mass = M_W'($urandom);
    end else begin
      jet.energy = E_W'($urandom_range(0, 8191));
      jet.px = P_W'(int'($urandom_range(0, 4095)) - 2048);
      jet.py = P_W'(int'($urandom_range(0, 4095)) - 2048);
      jet.pz = P_W'(int'($urandom_range(0, 4095)) - 2048);
      jet.mass = M_W'($urandom_range(0, 4095));
    end
    return jet;
  endfunction

  task automatic send_event(int size);
    for (int i = 0; i < size; i++) send_jet(random_jet(), i == size - 1);
  endtask

  initial begin
    jet_t hi, lo, sat, same;
    int size;
    hi = '{energy: '1, px: 21'h0FFFFF, py: 21'h0FFFFF, pz: 21'h0FFFFF, mass: '1};
    lo = '{energy: '0, px: 21'h100000, py: 21'h100000, pz: 21'h100000, mass: '0};
    sat = '{energy: '0, px: 21'h100000, py: 21'h100000, pz: 21'h100000, mass: '1};
    same = '{energy: 20'd800, px: 21'sd100, py: -21'sd50, pz: 21'sd30, mass: 20'd700};
    repeat (11) @(posedge clk);
    rst_n <= 1;

    send_jet(hi, 1);
    send_jet(lo, 0);
    send_jet(hi, 1);
    send_jet(hi, 0);
    send_jet(lo, 0);
    send_jet(hi, 1);
    send_jet(sat, 0);
    send_jet(sat, 0);
    send_jet(sat, 1);
    send_jet(same, 0);
    send_jet(same, 0);
    send_jet(same, 0);
    send_jet(same, 1);
    send_jet('0, 0);
    send_jet('0, 0);
    send_jet('0, 1);
    wait_drained();

    for (int ev = 0; jets_sent < 535; ev++) begin
      if (ev == 20 || ev == 90) size = $urandom_range(17, 20);
      else if (ev == 50) size = 16;
      else size = $urandom_range(1, 6);
      send_event(size);
      if (ev % 40 == 10) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d jets in %0d events: %0d short, %0d with dropped jets.",
             jets_sent, sb.events_seen, sb.short_events, sb.dropped_events);
    if (sb.errors == 0 && sb.pending_matches.size() == 0) begin
      $display("PASS jet_triplet_mass_matcher_core");
    end else begin
      $display("FAIL jet_triplet_mass_matcher_core");
    end
    $finish;
  end
endmodule

### sim.f
rtl/jtmm_pkg.sv
rtl/jtmm_datapath.sv
rtl/jtmm_ctrl.sv
rtl/jet_triplet_mass_matcher_core.sv
rtl/jtmm_checker.sv
dv/testbench.sv
